@@ rtl/core/lmc_pkg.sv @@
package lmc_pkg;

    localparam int unsigned PERIOD_W     = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd200;

    localparam int unsigned LED_N        = 4;
    localparam int unsigned MAN_N        = 3;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // switch codes
    localparam logic [1:0] SW_BLINK  = 2'd0;
    localparam logic [1:0] SW_ROTATE = 2'd1;
    localparam logic [1:0] SW_MANUAL = 2'd2;
    localparam logic [1:0] SW_CLEAR  = 2'd3;

    // run_mode output codes
    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_BLINK   = 2'd1;
    localparam logic [1:0] RUN_ROTATE  = 2'd2;

    typedef enum logic [2:0] {
        MODE_STOP   = 3'b001,
        MODE_BLINK  = 3'b010,
        MODE_ROTATE = 3'b100
    } t_mode;

    typedef struct packed {
        logic       command;
        logic [1:0] switch_index;
    } t_item;

    typedef struct packed {
        logic       manual_active;
        logic [1:0] run_mode;
        logic [LED_N-1:0] led_drive;
    } t_result;

    // handshake between input stage and engine
    typedef struct packed {
        logic valid;
    } t_link;

endpackage

@@ rtl/core/lmc_in_reg.sv @@
module lmc_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lmc_pkg::t_item   i_item,
    input  logic             i_down_ready,
    output lmc_pkg::t_link   o_link,
    output lmc_pkg::t_item   o_item
);

    logic           r_valid;
    logic           n_valid;
    lmc_pkg::t_item r_item;

    // stage frees when empty or when its beat moves on this cycle
    assign o_ready = !r_valid || i_down_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_link.valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ rtl/core/lmc_engine.sv @@
module lmc_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lmc_pkg::PERIOD_W-1:0]    i_period,
    input  lmc_pkg::t_link                  i_link,
    input  lmc_pkg::t_item                  i_item,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_out_ready,
    output lmc_pkg::t_result                o_result
);

    lmc_pkg::t_mode                   r_mode,    n_mode;
    logic                             r_manual,  n_manual;
    logic                             r_phase,   n_phase;
    logic [lmc_pkg::LED_N-1:0]        r_pattern, n_pattern;
    logic [lmc_pkg::MAN_N-1:0]        r_mlev,    n_mlev;
    logic [lmc_pkg::PERIOD_W-1:0]     r_ticks,   n_ticks;
    logic [lmc_pkg::LED_N-1:0]        r_leds,    n_leds;
    logic                             r_valid,   n_valid;
    lmc_pkg::t_result                 r_result,  n_result;

    logic                             take;
    logic [lmc_pkg::PERIOD_W-1:0]     tick_inc;
    logic [lmc_pkg::LED_N:0]          shifted;
    logic [lmc_pkg::MAN_N-1:0]        tog_bit;
    logic [lmc_pkg::MAN_N-1:0]        tog_lev;
    logic                             do_toggle;
    logic [1:0]                       run_code;

    assign o_ready = !r_valid || i_out_ready;
    assign take    = i_link.valid && o_ready;

    assign tick_inc = r_ticks + 1'b1;
    assign shifted  = {r_pattern, 1'b0};

    always_comb begin
        n_mode    = r_mode;
        n_manual  = r_manual;
        n_phase   = r_phase;
        n_pattern = r_pattern;
        n_mlev    = r_mlev;
        n_ticks   = r_ticks;
        n_leds    = r_leds;
        do_toggle = 1'b0;
        tog_bit   = '0;
        tog_lev   = '0;

        if (i_item.command == lmc_pkg::CMD_TICK) begin
            if (r_mode != lmc_pkg::MODE_STOP) begin
                n_ticks = tick_inc;
                // period 0 steps on every tick, same as 1
                if (tick_inc >= i_period) begin
                    n_ticks = '0;
                    if (r_mode == lmc_pkg::MODE_BLINK) begin
                        n_leds  = r_phase ? '0 : '1;
                        n_phase = !r_phase;
                    end else begin
                        n_leds = r_pattern;
                        if (shifted == 5'h10 || shifted == 5'h00) begin
                            n_pattern = 4'h1;
                        end else begin
                            n_pattern = shifted[lmc_pkg::LED_N-1:0];
                        end
                    end
                end
            end
        end else begin
            n_mode  = lmc_pkg::MODE_STOP;
            n_ticks = '0;
            case (i_item.switch_index)
                lmc_pkg::SW_BLINK: begin
                    if (!r_manual) n_mode = lmc_pkg::MODE_BLINK;
                    else do_toggle = 1'b1;
                end
                lmc_pkg::SW_ROTATE: begin
                    if (!r_manual) n_mode = lmc_pkg::MODE_ROTATE;
                    else do_toggle = 1'b1;
                end
                lmc_pkg::SW_MANUAL: begin
                    if (!r_manual) n_manual = 1'b1;
                    else do_toggle = 1'b1;
                end
                default: begin
                    n_manual = 1'b0;
                    n_mlev   = '0;
                    n_leds   = '0;
                end
            endcase
            if (do_toggle) begin
                tog_bit = lmc_pkg::MAN_N'(1) << i_item.switch_index;
                tog_lev = r_mlev ^ tog_bit;
                n_mlev  = tog_lev;
                n_leds  = (r_leds & ~{1'b0, tog_bit}) | {1'b0, tog_lev & tog_bit};
            end
        end
    end

    always_comb begin
        case (n_mode)
            lmc_pkg::MODE_BLINK:  run_code = lmc_pkg::RUN_BLINK;
            lmc_pkg::MODE_ROTATE: run_code = lmc_pkg::RUN_ROTATE;
            default:              run_code = lmc_pkg::RUN_STOPPED;
        endcase
    end

    always_comb begin
        n_valid  = r_valid;
        n_result = r_result;
        if (o_ready) begin
            n_valid = i_link.valid;
        end
        if (take) begin
            n_result.led_drive     = n_leds;
            n_result.run_mode      = run_code;
            n_result.manual_active = n_manual;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lmc_pkg::MODE_STOP;
            r_manual  <= 1'b0;
            r_phase   <= 1'b0;
            r_pattern <= 4'h1;
            r_mlev    <= '0;
            r_ticks   <= '0;
            r_leds    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (take) begin
                r_mode    <= n_mode;
                r_manual  <= n_manual;
                r_phase   <= n_phase;
                r_pattern <= n_pattern;
                r_mlev    <= n_mlev;
                r_ticks   <= n_ticks;
                r_leds    <= n_leds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/core/led_mode_controller.sv @@
// An accepted input beat passes the input register, then the state update
// into the result register, before it leaves as its result beat.
// Throughput: one beat per cycle while m_axis_tready is high; the result register decouples output stalls.
// Reset (i_rst_n low, synchronous): modes stopped, LEDs off, rotation at
// lowest LED, period 200 ticks, both pipeline stages empty.
module led_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // period_ticks

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] switch_index, [7:2] zero
    input  logic        s_axis_tuser,   // [0] command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [3:0] led_drive, [5:4] run_mode,
                                        // [6] manual_active, [7] zero
);

    logic [lmc_pkg::PERIOD_W-1:0] r_period;
    lmc_pkg::t_item               in_item;
    lmc_pkg::t_item               st_item;
    lmc_pkg::t_link               st_link;
    lmc_pkg::t_result             result;
    logic                         eng_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= lmc_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    assign in_item.command      = s_axis_tuser;
    assign in_item.switch_index = s_axis_tdata[1:0];

    lmc_in_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (in_item),
        .i_down_ready (eng_ready),
        .o_link       (st_link),
        .o_item       (st_item)
    );

    lmc_engine u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_period),
        .i_link      (st_link),
        .i_item      (st_item),
        .o_ready     (eng_ready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule
